// ----- rtl/efr_pkg.sv -----
// ----------------------------------------------------------------------------
// efr_pkg: shared types and constants of the escaped frame receiver
// Link control bytes, frame step encoding, status codes and the structs
// that pass between the unescape stage, the frame engine and the output buffer.
// ----------------------------------------------------------------------------
package efr_pkg;

  // Link control bytes
  localparam logic [7:0] BYTE_START = 8'hEB;
  localparam logic [7:0] BYTE_END   = 8'h30;
  localparam logic [7:0] BYTE_ESC   = 8'hEF;

  // Receive status codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RECV = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Frame step numbers as reported in error_stage
  localparam logic [2:0] STEP_NUM_WAIT = 3'd0;
  localparam logic [2:0] STEP_NUM_CMD  = 3'd1;
  localparam logic [2:0] STEP_NUM_LEN  = 3'd2;
  localparam logic [2:0] STEP_NUM_PAY  = 3'd3;
  localparam logic [2:0] STEP_NUM_CHK  = 3'd4;
  localparam logic [2:0] STEP_NUM_END  = 3'd5;

  // Frame steps, one-hot
  typedef enum logic [5:0] {
    STEP_WAIT = 6'b000001,
    STEP_CMD  = 6'b000010,
    STEP_LEN  = 6'b000100,
    STEP_PAY  = 6'b001000,
    STEP_CHK  = 6'b010000,
    STEP_END  = 6'b100000
  } step_t;

  // Unescaped view of one received byte
  typedef struct packed {
    logic       consumed;  // escape byte swallowed, no frame action
    logic       is_start;  // raw byte was the start byte
    logic [7:0] data;      // byte after unescaping
  } esc_t;

  // One result beat
  typedef struct packed {
    logic [1:0]  rx_status;
    logic [2:0]  error_stage;
    logic        frame_error;
    logic        frame_done;
    logic [7:0]  command_code;
    logic [15:0] payload_length;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
  } res_t;

  // Step number of a one-hot step
  function automatic logic [2:0] step_num(input step_t s);
    logic [2:0] n;
    n = STEP_NUM_WAIT;
    unique case (s)
      STEP_WAIT: n = STEP_NUM_WAIT;
      STEP_CMD:  n = STEP_NUM_CMD;
      STEP_LEN:  n = STEP_NUM_LEN;
      STEP_PAY:  n = STEP_NUM_PAY;
      STEP_CHK:  n = STEP_NUM_CHK;
      STEP_END:  n = STEP_NUM_END;
      default:   n = STEP_NUM_WAIT;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/efr_in_if.sv -----
// ----------------------------------------------------------------------------
// efr_in_if: received byte channel
// valid/ready handshake carrying one raw link byte per beat.
// ----------------------------------------------------------------------------
interface efr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/efr_out_if.sv -----
// ----------------------------------------------------------------------------
// efr_out_if: frame result channel
// valid/ready handshake carrying one result beat per received byte.
// ----------------------------------------------------------------------------
interface efr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  rx_status;
  logic [2:0]  error_stage;
  logic        frame_error;
  logic        frame_done;
  logic [7:0]  command_code;
  logic [15:0] payload_length;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;

  modport source (
    output valid, input ready,
    output rx_status, output error_stage, output frame_error, output frame_done,
    output command_code, output payload_length,
    output payload_valid, output payload_byte, output payload_index
  );
  modport sink (
    input valid, output ready,
    input rx_status, input error_stage, input frame_error, input frame_done,
    input command_code, input payload_length,
    input payload_valid, input payload_byte, input payload_index
  );
endinterface

// ----- rtl/efr_unescape.sv -----
// ----------------------------------------------------------------------------
// efr_unescape: escape removal
// Tracks the escape-pending flag and turns a raw byte into its unescaped
// value. The start byte is never unescaped and leaves the flag alone.
// ----------------------------------------------------------------------------
module efr_unescape (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic [7:0]    rx_byte,
  output efr_pkg::esc_t esc
);

  logic pending;
  logic pending_next;

  // Classify the byte and unescape
  always_comb begin
    esc.consumed = 1'b0;
    esc.is_start = 1'b0;
    esc.data     = rx_byte;
    pending_next = pending;
    priority if (rx_byte == efr_pkg::BYTE_START) begin
      esc.is_start = 1'b1;
    end else if (rx_byte == efr_pkg::BYTE_ESC && !pending) begin
      esc.consumed = 1'b1;
      pending_next = 1'b1;
    end else if (pending) begin
      esc.data     = rx_byte + efr_pkg::BYTE_ESC;  // wraps mod 256
      pending_next = 1'b0;
    end else begin
      // plain byte, passes through
      pending_next = pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (fire) begin
      pending <= pending_next;
    end
  end

endmodule

// ----- rtl/efr_frame.sv -----
// ----------------------------------------------------------------------------
// efr_frame: frame step engine
// Walks start, command, length, payload, checksum and end steps, keeps the
// running 8-bit sum and builds the result beat for each accepted byte.
// ----------------------------------------------------------------------------
module efr_frame (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  efr_pkg::esc_t esc,
  output efr_pkg::res_t res
);

  efr_pkg::step_t step, step_next;
  logic [15:0]    cnt, cnt_next;
  logic [15:0]    len, len_next;
  logic [7:0]     cmd, cmd_next;
  logic [7:0]     sum, sum_next;
  logic [1:0]     status, status_next;
  logic [2:0]     failed, failed_next;

  efr_pkg::step_t cur;
  logic [15:0]    len_full;
  logic [15:0]    cnt_inc;

  assign len_full = len | {esc.data, 8'h00};
  assign cnt_inc  = cnt + 16'd1;

  // Next state and result for the current byte
  always_comb begin
    cur         = step;
    cnt_next    = cnt;
    len_next    = len;
    cmd_next    = cmd;
    sum_next    = sum;
    status_next = status;
    failed_next = failed;
    res.frame_error   = 1'b0;
    res.frame_done    = 1'b0;
    res.payload_valid = 1'b0;
    res.payload_byte  = 8'h00;
    res.payload_index = 16'h0000;

    // start byte mid-frame: error, then the same byte reopens a frame
    if (esc.is_start && step != efr_pkg::STEP_WAIT) begin
      failed_next     = efr_pkg::step_num(step);
      cur             = efr_pkg::STEP_WAIT;
      status_next     = efr_pkg::ST_ERR;
      res.frame_error = 1'b1;
    end

    step_next = cur;
    if (!esc.consumed) begin
      unique case (cur)
        efr_pkg::STEP_WAIT: begin
          if (esc.data == efr_pkg::BYTE_START) begin
            step_next   = efr_pkg::STEP_CMD;
            status_next = efr_pkg::ST_RECV;
            sum_next    = efr_pkg::BYTE_START;
          end
        end
        efr_pkg::STEP_CMD: begin
          cmd_next  = esc.data;
          sum_next  = sum + esc.data;
          step_next = efr_pkg::STEP_LEN;
          cnt_next  = 16'h0000;
        end
        efr_pkg::STEP_LEN: begin
          sum_next = sum + esc.data;
          if (cnt == 16'h0000) begin
            len_next = {8'h00, esc.data};
            cnt_next = 16'h0001;
          end else begin
            len_next  = len_full;
            cnt_next  = 16'h0000;
            step_next = (len_full == 16'h0000) ? efr_pkg::STEP_CHK : efr_pkg::STEP_PAY;
          end
        end
        efr_pkg::STEP_PAY: begin
          sum_next          = sum + esc.data;
          res.payload_valid = 1'b1;
          res.payload_byte  = esc.data;
          res.payload_index = cnt;
          cnt_next          = cnt_inc;
          if (cnt_inc >= len) begin
            step_next = efr_pkg::STEP_CHK;
          end
        end
        efr_pkg::STEP_CHK: begin
          if (sum == esc.data) begin
            step_next = efr_pkg::STEP_END;
          end else begin
            failed_next     = efr_pkg::STEP_NUM_CHK;
            step_next       = efr_pkg::STEP_WAIT;
            status_next     = efr_pkg::ST_ERR;
            res.frame_error = 1'b1;
          end
        end
        efr_pkg::STEP_END: begin
          if (esc.data == efr_pkg::BYTE_END) begin
            status_next    = efr_pkg::ST_DONE;
            step_next      = efr_pkg::STEP_WAIT;
            res.frame_done = 1'b1;
          end
        end
        default: begin
          step_next = cur;
        end
      endcase
    end

    res.rx_status      = status_next;
    res.error_stage    = failed_next;
    res.command_code   = cmd_next;
    res.payload_length = len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= efr_pkg::STEP_WAIT;
      cnt    <= 16'h0000;
      len    <= 16'h0000;
      cmd    <= 8'h00;
      sum    <= 8'h00;
      status <= efr_pkg::ST_IDLE;
      failed <= efr_pkg::STEP_NUM_WAIT;
    end else if (fire) begin
      step   <= step_next;
      cnt    <= cnt_next;
      len    <= len_next;
      cmd    <= cmd_next;
      sum    <= sum_next;
      status <= status_next;
      failed <= failed_next;
    end
  end

`ifndef ASSERT_OFF
  // A byte never both fails and completes a frame
  a_err_done_excl: assert property (@(posedge clk) disable iff (rst)
    fire |-> !(res.frame_error && res.frame_done))
    else $error("frame_error and frame_done in the same beat");

  // A completed frame returns the engine to waiting for start
  a_done_to_wait: assert property (@(posedge clk) disable iff (rst)
    fire && res.frame_done |=> step == efr_pkg::STEP_WAIT && status == efr_pkg::ST_DONE)
    else $error("frame done but engine not back at wait");

  // Payload beats only while a frame is being received
  a_payload_recv: assert property (@(posedge clk) disable iff (rst)
    fire && res.payload_valid |-> status == efr_pkg::ST_RECV && step == efr_pkg::STEP_PAY)
    else $error("payload beat outside payload step");
`endif

endmodule

// ----- rtl/efr_obuf.sv -----
// ----------------------------------------------------------------------------
// efr_obuf: result output buffer
// Output register plus one skid entry, so the upstream ready is registered
// and a byte can be taken every cycle while the sink keeps up.
// ----------------------------------------------------------------------------
module efr_obuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  efr_pkg::res_t   in_data,
  efr_out_if.source       out
);

  efr_pkg::res_t main_q;
  efr_pkg::res_t skid_q;
  logic          main_valid;
  logic          skid_valid;
  logic          in_fire;
  logic          out_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = main_valid && out.ready;

  // Control: main register drains first, skid catches a stalled beat
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_fire || !main_valid) begin
      if (skid_valid) begin
        main_q <= skid_q;
      end else if (in_fire) begin
        main_q <= in_data;
      end
    end else if (in_fire) begin
      skid_q <= in_data;
    end
  end

  assign out.valid          = main_valid;
  assign out.rx_status      = main_q.rx_status;
  assign out.error_stage    = main_q.error_stage;
  assign out.frame_error    = main_q.frame_error;
  assign out.frame_done     = main_q.frame_done;
  assign out.command_code   = main_q.command_code;
  assign out.payload_length = main_q.payload_length;
  assign out.payload_valid  = main_q.payload_valid;
  assign out.payload_byte   = main_q.payload_byte;
  assign out.payload_index  = main_q.payload_index;

`ifndef ASSERT_OFF
  // The skid entry is only used behind a held output beat
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry filled with output register empty");

  // A beat taken while the output stalls lands in the skid entry
  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    in_fire && main_valid && !out.ready |=> skid_valid && main_valid)
    else $error("stalled beat not held in skid entry");
`endif

endmodule

// ----- rtl/escaped_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_receiver: byte-stuffed frame receiver with additive checksum
// Removes escaping from the received byte stream, tracks the frame steps,
// checks the 8-bit sum and emits one result beat per received byte.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                   beats
//   rx       in   rx_byte                                   one raw byte
//   result   out  status, error step, pulses, command,      one per rx beat
//                 length, payload byte and index
//
// Unescape and frame step update sit between the rx handshake and the output
// register, so a byte can enter every cycle while the result side keeps up.
// A result reaches the result channel from the output register, via the skid entry on a stall.
// Reset (rst, synchronous) returns the engine to waiting for start, idle.
// When result stalls, one more byte is taken into the skid entry, then rx
// ready drops until the held output beat is taken.
// ----------------------------------------------------------------------------
module escaped_frame_receiver (
  input  logic      clk,
  input  logic      rst,
  efr_in_if.sink    rx,
  efr_out_if.source result
);

  efr_pkg::esc_t esc;
  efr_pkg::res_t res;
  logic          fire;

  assign fire = rx.valid && rx.ready;

  efr_unescape u_unescape (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (rx.rx_byte),
    .esc     (esc)
  );

  efr_frame u_frame (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .esc  (esc),
    .res  (res)
  );

  efr_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .in_data  (res),
    .out      (result)
  );

endmodule

// ----- tb/efr_frame_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// efr_frame_checker: result checker for the escaped frame receiver
// Watches the rx and result channels. Every accepted rx beat runs through a
// cycle-free model of the unescape stage and frame engine, and the expected
// result beat is queued. Every accepted result beat is compared field by
// field with the oldest queued beat. Mismatch and pending counts go to the top.
// ----------------------------------------------------------------------------
module efr_frame_checker
  import efr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  efr_in_if    rx,
  efr_out_if   result,
  output int   fail_count,
  output int   pending_beats,
  output int   frames_done,
  output int   frames_failed,
  output int   payload_beats
);

  // Model state of the frame engine
  logic [2:0]  step_q;
  logic        esc_armed;
  logic [15:0] byte_cnt;
  logic [15:0] len_q;
  logic [7:0]  cmd_q;
  logic [7:0]  sum_q;
  logic [1:0]  status_q;
  logic [2:0]  fail_step_q;

  res_t expected_beats[$];
  int   n_fail = 0;
  int   n_done = 0;
  int   n_err  = 0;
  int   n_pay  = 0;

  assign fail_count    = n_fail;
  assign frames_done   = n_done;
  assign frames_failed = n_err;
  assign payload_beats = n_pay;

  task automatic clear_frame_model();
    step_q      = STEP_NUM_WAIT;
    esc_armed   = 1'b0;
    byte_cnt    = '0;
    len_q       = '0;
    cmd_q       = '0;
    sum_q       = '0;
    status_q    = ST_IDLE;
    fail_step_q = STEP_NUM_WAIT;
  endtask

  task automatic abort_frame();
    fail_step_q = step_q;
    step_q      = STEP_NUM_WAIT;
    status_q    = ST_ERR;
  endtask

  // One raw link byte through unescape and the frame steps
  task automatic predict_frame_beat(input logic [7:0] raw, output res_t r);
    logic [7:0] data;
    logic       consumed;
    data     = raw;
    consumed = 1'b0;
    r        = '0;

    // unescape; a start byte is never unescaped and keeps the pending flag
    if (raw == BYTE_START) begin
      if (step_q != STEP_NUM_WAIT) begin
        abort_frame();
        r.frame_error = 1'b1;
      end
    end else if (raw == BYTE_ESC && !esc_armed) begin
      esc_armed = 1'b1;
      consumed  = 1'b1;
    end else if (esc_armed) begin
      data      = raw + BYTE_ESC;
      esc_armed = 1'b0;
    end

    if (!consumed) begin
      case (step_q)
        STEP_NUM_WAIT: begin
          if (data == BYTE_START) begin
            step_q   = STEP_NUM_CMD;
            status_q = ST_RECV;
            sum_q    = BYTE_START;
          end
        end
        STEP_NUM_CMD: begin
          cmd_q    = data;
          sum_q    = sum_q + data;
          step_q   = STEP_NUM_LEN;
          byte_cnt = '0;
        end
        STEP_NUM_LEN: begin
          sum_q = sum_q + data;
          if (byte_cnt == 16'd0) begin
            len_q    = {8'h00, data};
            byte_cnt = 16'd1;
          end else begin
            // high byte is ORed onto whatever the low byte left
            len_q    = len_q | {data, 8'h00};
            byte_cnt = '0;
            step_q   = (len_q == 16'd0) ? STEP_NUM_CHK : STEP_NUM_PAY;
          end
        end
        STEP_NUM_PAY: begin
          sum_q           = sum_q + data;
          r.payload_valid = 1'b1;
          r.payload_byte  = data;
          r.payload_index = byte_cnt;
          byte_cnt        = byte_cnt + 16'd1;
          if (byte_cnt >= len_q) step_q = STEP_NUM_CHK;
        end
        STEP_NUM_CHK: begin
          if (sum_q == data) begin
            step_q = STEP_NUM_END;
          end else begin
            abort_frame();
            r.frame_error = 1'b1;
          end
        end
        STEP_NUM_END: begin
          // anything but the end byte is dropped here
          if (data == BYTE_END) begin
            status_q     = ST_DONE;
            step_q       = STEP_NUM_WAIT;
            r.frame_done = 1'b1;
          end
        end
        default: ;
      endcase
    end

    r.rx_status      = status_q;
    r.error_stage    = fail_step_q;
    r.command_code   = cmd_q;
    r.payload_length = len_q;
  endtask

  function automatic bit field_bad(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  initial clear_frame_model();

  // Predict on rx beats, compare on result beats
  always @(posedge clk) begin
    res_t want;
    int   bad;
    if (rst) begin
      clear_frame_model();
      expected_beats.delete();
    end else begin
      if (rx.valid && rx.ready) begin
        predict_frame_beat(rx.rx_byte, want);
        expected_beats.push_back(want);
        if (want.frame_done) n_done++;
        if (want.frame_error) n_err++;
        if (want.payload_valid) n_pay++;
      end
      if (result.valid && result.ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no rx byte outstanding");
          n_fail++;
        end else begin
          want = expected_beats.pop_front();
          bad  = 0;
          bad += field_bad("rx_status", want.rx_status, result.rx_status);
          bad += field_bad("error_stage", want.error_stage, result.error_stage);
          bad += field_bad("frame_error", want.frame_error, result.frame_error);
          bad += field_bad("frame_done", want.frame_done, result.frame_done);
          bad += field_bad("command_code", want.command_code, result.command_code);
          bad += field_bad("payload_length", want.payload_length, result.payload_length);
          bad += field_bad("payload_valid", want.payload_valid, result.payload_valid);
          bad += field_bad("payload_byte", want.payload_byte, result.payload_byte);
          bad += field_bad("payload_index", want.payload_index, result.payload_index);
          if (bad != 0) n_fail++;
        end
      end
    end
    pending_beats = expected_beats.size();
  end

endmodule

// ----- tb/escaped_frame_receiver_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escaped_frame_receiver_tb: stimulus and verdict for the frame receiver
// Feeds escaped link bytes: a short directed set of frames covering escapes,
// zero length, checksum failures and restarts in the command, length, payload
// and end steps, then random frames, mostly well formed, mixed with broken
// frames and line noise. The sender works in bursts, the result side stalls in changing patterns.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_tb;
  import efr_pkg::*;

  // result-side stall patterns
  localparam int RDY_ALWAYS = 0;
  localparam int RDY_MOSTLY = 1;
  localparam int RDY_RARELY = 2;
  localparam int RDY_TOGGLE = 3;

  logic clk = 1'b0;
  logic rst;

  efr_in_if  rx_ch ();
  efr_out_if res_ch ();

  int fail_count, pending_beats, frames_done, frames_failed, payload_beats;

  escaped_frame_receiver dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch)
  );

  efr_frame_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .rx            (rx_ch),
    .result        (res_ch),
    .fail_count    (fail_count),
    .pending_beats (pending_beats),
    .frames_done   (frames_done),
    .frames_failed (frames_failed),
    .payload_beats (payload_beats)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result stall pattern, switches to a randomly chosen mode when its run count runs out
  int   rdy_mode  = RDY_ALWAYS;
  int   rdy_left  = 0;
  logic rdy_phase = 1'b0;
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(RDY_TOGGLE, RDY_ALWAYS);
      rdy_left = $urandom_range(200, 32);
    end else begin
      rdy_left--;
    end
    case (rdy_mode)
      RDY_ALWAYS: res_ch.ready <= 1'b1;
      RDY_MOSTLY: res_ch.ready <= ($urandom_range(3) != 0);
      RDY_RARELY: res_ch.ready <= ($urandom_range(3) == 0);
      default: begin
        rdy_phase = ~rdy_phase;
        res_ch.ready <= rdy_phase;
      end
    endcase
  end

  logic [7:0] link_bytes[$];
  logic [7:0] pay[$];
  int         burst_left = 0;
  int         bytes_sent = 0;

  // Payload and command data, biased toward the control bytes
  function automatic logic [7:0] rand_data();
    case ($urandom_range(15))
      0:       return BYTE_START;
      1:       return BYTE_ESC;
      2:       return BYTE_END;
      3:       return 8'hDA;
      4:       return 8'hDE;
      5:       return 8'h00;
      6:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One data byte on the link, escaped where needed or now and then by choice.
  // 0xDA cannot be escaped: its escaped form would be the start byte.
  task automatic put_data(input logic [7:0] d);
    if (d == BYTE_START || d == BYTE_ESC || d == 8'hDE ||
        (d != 8'hDA && $urandom_range(9) == 0)) begin
      link_bytes.push_back(BYTE_ESC);
      link_bytes.push_back(8'(d - BYTE_ESC));
    end else begin
      link_bytes.push_back(d);
    end
  endtask

  // A frame on the link. cut != 0 stops after that many frame items, so the
  // next start byte hits the engine mid-frame.
  task automatic put_frame(input logic [7:0] cmd, input logic [15:0] len, input int cut,
                           input logic [7:0] sum_flip, input int junk_n,
                           input bit esc_end, input bit esc_start);
    logic [7:0] body[$];
    logic [7:0] sum;
    logic [7:0] junk;
    int         k;
    body = {cmd, len[7:0], len[15:8]};
    foreach (pay[i]) body.push_back(pay[i]);
    if (esc_start) begin
      link_bytes.push_back(BYTE_ESC);
      link_bytes.push_back(8'(BYTE_START - BYTE_ESC));
    end else begin
      link_bytes.push_back(BYTE_START);
    end
    sum = BYTE_START;
    k   = 1;
    foreach (body[i]) begin
      if (k == cut) return;
      put_data(body[i]);
      sum = sum + body[i];
      k++;
    end
    if (k == cut) return;
    put_data(sum ^ sum_flip);
    k++;
    if (k == cut) return;
    // bytes that the engine drops while it waits for the end byte
    repeat (junk_n) begin
      do junk = 8'($urandom_range(255));
      while (junk == BYTE_END || junk == BYTE_START || junk == BYTE_ESC);
      link_bytes.push_back(junk);
    end
    if (esc_end) begin
      link_bytes.push_back(BYTE_ESC);
      link_bytes.push_back(8'(BYTE_END - BYTE_ESC));
    end else begin
      link_bytes.push_back(BYTE_END);
    end
  endtask

  task automatic fill_payload(input int n);
    pay.delete();
    repeat (n) pay.push_back(rand_data());
  endtask

  // Send one beat, with random gaps between bursts
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(3) == 0) begin
        burst_left = $urandom_range(150, 50);
      end else begin
        rx_ch.valid <= 1'b0;
        gap = $urandom_range(8, 1);
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(20, 1);
      end
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk);
    while (!rx_ch.ready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic flush_link();
    while (link_bytes.size() != 0) send_byte(link_bytes.pop_front());
  endtask

  // Stop sending until every expected result beat has come back
  task automatic hold_until_drained();
    rx_ch.valid <= 1'b0;
    do @(posedge clk);
    while (pending_beats != 0);
  endtask

  initial begin
    int         r;
    int         n;
    int         frame_no;
    bit         prev_cut;
    logic [15:0] len;

    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero length, control bytes in payload, escaped end, junk
    pay.delete();
    put_frame(8'h00, 16'd0, 0, 8'h00, 0, 1'b0, 1'b0);
    pay = {BYTE_START, BYTE_ESC, BYTE_END, 8'hDE, 8'hDA};
    put_frame(8'hFF, 16'd5, 0, 8'h00, 0, 1'b0, 1'b0);
    pay = {8'h00, 8'hFF};
    put_frame(8'h5A, 16'd2, 0, 8'h00, 3, 1'b1, 1'b0);
    // checksum mismatch, then the end byte lands in the idle step
    pay = {8'h42};
    put_frame(8'h11, 16'd1, 0, 8'h01, 0, 1'b0, 1'b0);
    // restart by a start byte in the command, length, payload and end steps
    pay = {8'h01, 8'h02, 8'h03, 8'h04};
    put_frame(8'h21, 16'd4, 1, 8'h00, 0, 1'b0, 1'b0);
    put_frame(8'h22, 16'd4, 2, 8'h00, 0, 1'b0, 1'b0);
    put_frame(8'h23, 16'd4, 3, 8'h00, 0, 1'b0, 1'b0);
    put_frame(8'h24, 16'd4, 6, 8'h00, 0, 1'b0, 1'b0);
    put_frame(8'h25, 16'd4, 9, 8'h00, 0, 1'b0, 1'b0);
    put_frame(8'h26, 16'd4, 10, 8'h00, 0, 1'b0, 1'b0);
    pay.delete();
    put_frame(8'h27, 16'd0, 0, 8'h00, 0, 1'b0, 1'b0);
    // frame opened by an escaped start byte
    pay = {8'h30};
    put_frame(8'h80, 16'd1, 0, 8'h00, 0, 1'b0, 1'b1);
    // escape pending across a raw start byte, and noise while idle
    link_bytes.push_back(BYTE_ESC);
    pay.delete();
    put_frame(8'h41, 16'd0, 0, 8'h00, 0, 1'b0, 1'b0);
    link_bytes = {link_bytes, BYTE_END, 8'h00, 8'hFF, BYTE_ESC, BYTE_ESC, 8'h12};
    // largest declared length, cut short
    pay = {8'hAA, 8'h55, 8'h0F};
    put_frame(8'h7E, 16'hFFFF, 7, 8'h00, 0, 1'b0, 1'b0);
    pay.delete();
    put_frame(8'h01, 16'd0, 0, 8'h00, 0, 1'b0, 1'b0);
    flush_link();
    hold_until_drained();

    // Random frames, mostly well formed
    frame_no = 0;
    prev_cut = 1'b0;
    while (bytes_sent < 1250) begin
      r   = $urandom_range(99);
      len = ($urandom_range(19) == 0) ? 16'($urandom_range(64, 13)) : 16'($urandom_range(12));
      if (frame_no == 40) len = 16'h0100;
      fill_payload(len);
      if (r < 70) begin
        put_frame(rand_data(), len, 0, 8'h00,
                  ($urandom_range(5) == 0) ? $urandom_range(4, 1) : 0,
                  ($urandom_range(7) == 0), !prev_cut && ($urandom_range(7) == 0));
        prev_cut = 1'b0;
      end else if (r < 80) begin
        put_frame(rand_data(), len, 0, 8'($urandom_range(255, 1)), 0, 1'b0, 1'b0);
        prev_cut = 1'b0;
      end else if (r < 90) begin
        put_frame(rand_data(), len, $urandom_range(5 + len, 1), 8'h00, 0, 1'b0, 1'b0);
        prev_cut = 1'b1;
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) link_bytes.push_back(8'($urandom_range(255)));
      end
      flush_link();
      frame_no++;
      if (frame_no == 60) hold_until_drained();
    end

    hold_until_drained();
    repeat (4) @(posedge clk);

    $display("covered %0d link bytes in %0d random steps: %0d frames done, %0d frame errors,",
             bytes_sent, frame_no, frames_done, frames_failed);
    $display("  %0d payload beats, escapes and restarts at every frame step", payload_beats);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/efr_pkg.sv
rtl/efr_in_if.sv
rtl/efr_out_if.sv
rtl/efr_unescape.sv
rtl/efr_frame.sv
rtl/efr_obuf.sv
rtl/escaped_frame_receiver.sv
tb/efr_frame_checker.sv
tb/escaped_frame_receiver_tb.sv
